// ===== design/correlating_branch_predictor_unit_assert.svh =====
// Assertion macros for the branch predictor.
`ifndef CORRELATING_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`define CORRELATING_BRANCH_PREDICTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbp assertion failed");

// Next-cycle implication, disabled during reset.
`define CBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbp assertion failed");

`endif

// ===== design/cbp_pkg.sv =====
package cbp_pkg;

  localparam int ADDR_BITS_DEF = 10;
  localparam int HIST_BITS_DEF = 2;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_STRONG_NT = 2'd0;
  localparam ctr_t CTR_WEAK_NT   = 2'd1;
  localparam ctr_t CTR_WEAK_T    = 2'd2;
  localparam ctr_t CTR_STRONG_T  = 2'd3;
  localparam ctr_t CTR_RESET     = CTR_STRONG_T;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

  function automatic ctr_t next_counter(input ctr_t c, input logic t);
    ctr_t n;
    if (t) begin
      n = (c == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
    end else begin
      n = (c == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
    end
    return n;
  endfunction

endpackage

// ===== design/cbp_table.sv =====
module cbp_table #(
  parameter int IDX_BITS = cbp_pkg::HIST_BITS_DEF + cbp_pkg::ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cbp_pkg::tbl_ctrl_t  ctrl,
  input  logic [IDX_BITS-1:0] rd_idx,
  output cbp_pkg::ctr_t       rd_data,
  input  logic [IDX_BITS-1:0] wr_idx,
  input  cbp_pkg::ctr_t       wr_data,
  output logic                busy
);
  import cbp_pkg::*;

  localparam int Depth = 1 << IDX_BITS;

  ctr_t                mem [Depth];
  logic [IDX_BITS-1:0] clr_idx;

  // reset sweep: writes every entry to the reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == IDX_BITS'(Depth - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= CTR_RESET;
    end else if (ctrl.wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== design/correlating_branch_predictor_unit.sv =====
// Correlating (m,n) branch predictor.
// Input channel: in_valid/in_ready carry one resolved branch per item
// (branch_address, taken). Output channel: out_valid/out_ready carry one
// prediction per item, in input order; prediction is the counter state
// before that branch's own update.
// Index = {global history, low ADDR_BITS of address}; predict taken when
// the 2-bit counter is 2 or 3.
// The accepted item is registered in the middle stage (s1), and out_valid
// rises when s1 moves into the result register. One item per cycle while
// the output is not held; the table is a single memory with one read and
// one write port, and a same-index write from the previous item is forwarded.
// Reset: history goes to all ones and a sweep writes 3 to each of the
// 2**(HIST_BITS+ADDR_BITS) table entries (4096 by default);
// in_ready is low during the sweep.
// Stall: a held output keeps the result register, the middle stage holds
// one more item, then in_ready drops until out_ready returns.
`include "correlating_branch_predictor_unit_assert.svh"

module correlating_branch_predictor_unit #(
  parameter int ADDR_BITS = cbp_pkg::ADDR_BITS_DEF,
  parameter int HIST_BITS = cbp_pkg::HIST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] branch_address,
  input  logic        taken,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        prediction
);
  import cbp_pkg::*;

  localparam int IdxBits = HIST_BITS + ADDR_BITS;

  logic [HIST_BITS-1:0] history;
  logic [HIST_BITS:0]   hist_shift;
  logic [IdxBits-1:0]   in_idx;
  logic                 accept;
  logic                 s1_valid;
  logic                 s1_adv;
  logic [IdxBits-1:0]   s1_idx;
  logic                 s1_taken;
  logic                 fwd_hit;
  ctr_t                 fwd_val;
  ctr_t                 rd_data;
  ctr_t                 s1_ctr;
  ctr_t                 s1_ctr_next;
  logic                 busy;
  tbl_ctrl_t            tbl_ctrl;

  assign s1_adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready    = !busy && (!s1_valid || s1_adv);
  assign accept      = in_valid && in_ready;
  assign in_idx      = {history, branch_address[ADDR_BITS-1:0]};
  assign hist_shift  = {history, taken};
  assign s1_ctr      = fwd_hit ? fwd_val : rd_data;
  assign s1_ctr_next = next_counter(s1_ctr, s1_taken);

  assign tbl_ctrl.rd_en = accept;
  assign tbl_ctrl.wr_en = s1_adv;

  cbp_table #(
    .IDX_BITS(IdxBits)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (tbl_ctrl),
    .rd_idx (in_idx),
    .rd_data(rd_data),
    .wr_idx (s1_idx),
    .wr_data(s1_ctr_next),
    .busy   (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      history   <= '1;
      s1_valid  <= 1'b0;
      fwd_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        history  <= hist_shift[HIST_BITS-1:0];
        s1_valid <= 1'b1;
        fwd_hit  <= s1_adv && (s1_idx == in_idx);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
        fwd_hit  <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx   <= in_idx;
      s1_taken <= taken;
      fwd_val  <= s1_ctr_next;
    end
    if (s1_adv) begin
      prediction <= s1_ctr[1];
    end
  end

  `CBP_ASSERT_NOW(a_idle_in_sweep, busy, !s1_valid && !out_valid)
  `CBP_ASSERT_NOW(a_fwd_live, fwd_hit, s1_valid)
  `CBP_ASSERT_NEXT(a_hist_newest, accept, history[0] == $past(taken))
  `CBP_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv, s1_valid && $stable(s1_idx))

endmodule

// ===== tb/correlating_branch_predictor_unit_test.sv =====
`timescale 1ns / 100ps

module correlating_branch_predictor_unit_test;
  import cbp_pkg::*;

  localparam int ADDR_W = ADDR_BITS_DEF;
  localparam int HIST_W = HIST_BITS_DEF;
  localparam int IDX_W = ADDR_W + HIST_W;
  localparam int PHT_DEPTH = 1 << IDX_W;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int N_DIR = 25;

  // alias of 32'h0000_0155 in the low bits: 32'hABCD_E955
  localparam logic [31:0] DIR_ADDR [N_DIR] = '{
    32'h0000_0155, 32'h0000_0155, 32'h0000_0155, 32'hABCD_E955, 32'h0000_0155,
    32'h0000_0155, 32'h0000_02AA, 32'h0000_02AA, 32'h0000_0155, 32'h0000_0155,
    32'h0000_02AA, 32'h0000_02AA, 32'hABCD_E955, 32'h0000_02AA, 32'h0000_02AA,
    32'h0000_0155, 32'h0000_02AA, 32'h0000_02AA, 32'h0000_0155, 32'h0000_0155,
    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FC00, 32'h0000_03FF, 32'h8000_0000
  };
  localparam logic DIR_TAKEN [N_DIR] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b1, 1'b1, 1'b0, 1'b1, 1'b0
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] branch_address = '0;
  logic        taken = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        prediction;

  ctr_t              pht [PHT_DEPTH];
  logic [HIST_W-1:0] branch_hist;
  logic              predicted_q [$];
  logic [ADDR_W-1:0] hot_index [4];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  bit  hold_active = 0;
  event stall_go;

  correlating_branch_predictor_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .branch_address (branch_address),
    .taken          (taken),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prediction     (prediction)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // updates the shadow table and history, returns the prediction seen by this branch
  function automatic logic predict_branch(input logic [31:0] addr, input logic t);
    logic [IDX_W-1:0] idx;
    ctr_t c;
    ctr_t n;
    idx = {branch_hist, addr[ADDR_W-1:0]};
    c = pht[idx];
    case (c)
      CTR_STRONG_NT: n = t ? CTR_WEAK_NT : CTR_STRONG_NT;
      CTR_WEAK_NT, CTR_WEAK_T: n = t ? CTR_STRONG_T : CTR_STRONG_NT;
      default: n = t ? CTR_STRONG_T : CTR_WEAK_T;
    endcase
    pht[idx] = n;
    branch_hist = HIST_W'({branch_hist, t});
    return c >= CTR_WEAK_T;
  endfunction

  task automatic send_branch(input logic [31:0] addr, input logic t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    branch_address <= addr;
    taken <= t;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predicted_q.push_back(predict_branch(addr, t));
  endtask

  task automatic send_random_branch();
    logic [31:0] addr;
    addr = $urandom();
    if ($urandom_range(99) < 70) addr[ADDR_W-1:0] = hot_index[$urandom_range(3)];
    send_branch(addr, $urandom_range(99) < 70);
  endtask

  task automatic wait_drained();
    while (predicted_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < N_DIR; i++) send_branch(DIR_ADDR[i], DIR_TAKEN[i]);
  endtask

  task automatic test_random_stream(input int n, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    foreach (hot_index[i]) hot_index[i] = ADDR_W'($urandom());
    for (int i = 0; i < n; i++) send_random_branch();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    -> stall_go;
    for (int i = 0; i < 40; i++) send_random_branch();
    in_valid <= 1'b0;
    wait_drained();
    recv_idle_pct = 50;
    for (int i = 0; i < 20; i++) send_random_branch();
  endtask

  initial begin
    forever begin
      @(stall_go);
      hold_active = 1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 0;
    end
  end

  always @(posedge clk) begin
    out_ready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (predicted_q.size() == 0) begin
        report_mismatch("prediction with no item outstanding");
      end else begin
        logic exp_pred;
        exp_pred = predicted_q.pop_front();
        if (prediction !== exp_pred)
          report_mismatch($sformatf("prediction %b, expected %b", prediction, exp_pred));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (pht[i]) pht[i] = CTR_RESET;
    branch_hist = '1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_stream(280, 31, 66);
    test_random_stream(280, 66, 31);
    test_random_stream(280, 0, 0);
    test_backpressure();
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/cbp_pkg.sv
design/cbp_table.sv
design/correlating_branch_predictor_unit.sv
tb/correlating_branch_predictor_unit_test.sv
